@@ design/sensor_frame_parser_assert.svh @@
// Assertion macros shared by the sensor frame parser modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef SENSOR_FRAME_PARSER_ASSERT_SVH
`define SENSOR_FRAME_PARSER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SFP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by a result in the next.
`define SFP_ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
		else $error(msg);

`endif

@@ design/sfp_pkg.sv @@
// Shared types, codes and helper functions of the sensor frame parser.
// Depends on nothing; imported by every module of the block.
package sfp_pkg;

	localparam int unsigned NUM_MODES = 5;
	localparam logic [2:0] CLASS_NONE = 3'd5;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_MODE    = 3'd1,
		PH_SIZE0   = 3'd2,
		PH_SIZE1   = 3'd3,
		PH_DATA    = 3'd4,
		PH_TRAILER = 3'd5,
		PH_TAIL    = 3'd6,
		PH_DONE    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		REG_HEADER_SYMBOL   = 3'd0,
		REG_CODE_GRID       = 3'd1,
		REG_CODE_CORRECTION = 3'd2,
		REG_CODE_HIGH_RES   = 3'd3,
		REG_CODE_HUMAN      = 3'd4,
		REG_CODE_COMM_ERROR = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		CLASS_GRID        = 3'd0,
		CLASS_CORRECTION  = 3'd1,
		CLASS_HIGH_RES    = 3'd2,
		CLASS_HUMAN       = 3'd3,
		CLASS_COMM_ERROR  = 3'd4
	} class_t;

	localparam logic [7:0] TAIL_GRID       = 8'h3F;
	localparam logic [7:0] TAIL_CORRECTION = 8'h9F;
	localparam logic [7:0] TAIL_HIGH_RES   = 8'h8F;
	localparam logic [7:0] TAIL_HUMAN      = 8'h9F;
	localparam logic [7:0] TAIL_COMM_ERROR = 8'hEF;

	typedef struct packed {
		logic [7:0]                     header_symbol;
		logic [NUM_MODES-1:0][7:0]      mode_code;
	} cfg_t;

	typedef struct packed {
		phase_t      parser_state;
		logic        payload_valid;
		logic [15:0] payload_index;
		logic [7:0]  payload_byte;
		logic        frame_done;
		logic [2:0]  frame_class;
		logic [15:0] frame_length;
	} result_t;

	// First matching code wins; CLASS_NONE when nothing matches.
	function automatic logic [2:0] classify(input cfg_t cfg, input logic [7:0] b);
		logic [2:0] c;
		c = CLASS_NONE;
		for (int k = NUM_MODES - 1; k >= 0; k--) begin
			if (cfg.mode_code[k] == b) begin
				c = 3'(k);
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] tail_code(input logic [2:0] c);
		logic [7:0] t;
		case (class_t'(c))
			CLASS_GRID:       t = TAIL_GRID;
			CLASS_CORRECTION: t = TAIL_CORRECTION;
			CLASS_HIGH_RES:   t = TAIL_HIGH_RES;
			CLASS_HUMAN:      t = TAIL_HUMAN;
			CLASS_COMM_ERROR: t = TAIL_COMM_ERROR;
			default:          t = 8'h00;
		endcase
		return t;
	endfunction

endpackage

@@ design/sfp_cfg_regs.sv @@
// Configuration register file: header symbol and the five mode codes.
// Depends on sfp_pkg.
module sfp_cfg_regs
	import sfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_HEADER_SYMBOL:   cfg_q.header_symbol <= wr_data;
				REG_CODE_GRID:       cfg_q.mode_code[0] <= wr_data;
				REG_CODE_CORRECTION: cfg_q.mode_code[1] <= wr_data;
				REG_CODE_HIGH_RES:   cfg_q.mode_code[2] <= wr_data;
				REG_CODE_HUMAN:      cfg_q.mode_code[3] <= wr_data;
				REG_CODE_COMM_ERROR: cfg_q.mode_code[4] <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/sfp_parse.sv @@
// Frame parser state and the per-item next-state and result logic.
// Depends on sfp_pkg and sensor_frame_parser_assert.svh.
`include "sensor_frame_parser_assert.svh"
module sfp_parse
	import sfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       op,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic [2:0]  class_q, class_d;
	logic [15:0] goal_q, goal_d;
	logic [15:0] taken_q, taken_d;
	logic [15:0] taken_inc;
	logic [15:0] product;
	logic [2:0]  match;

	assign taken_inc = taken_q + 16'd1;
	assign product   = {8'h00, goal_q[7:0]} * {8'h00, rx_byte};
	assign match     = classify(cfg, rx_byte);

	always_comb begin
		phase_d = phase_q;
		class_d = class_q;
		goal_d  = goal_q;
		taken_d = taken_q;
		res     = '0;
		if (op) begin
			phase_d = PH_MODE;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (rx_byte == cfg.header_symbol) phase_d = PH_MODE;
				end
				PH_MODE: begin
					if (match != CLASS_NONE) begin
						class_d = match;
						phase_d = PH_SIZE0;
					end else begin
						phase_d = PH_HEADER;
					end
				end
				PH_SIZE0: begin
					goal_d  = {8'h00, rx_byte};
					phase_d = PH_SIZE1;
				end
				PH_SIZE1: begin
					if (rx_byte != 8'h00) goal_d = product;
					taken_d = '0;
					phase_d = PH_DATA;
				end
				PH_DATA: begin
					res.payload_valid = 1'b1;
					res.payload_index = taken_q;
					res.payload_byte  = rx_byte;
					taken_d           = taken_inc;
					if (taken_inc >= goal_q) phase_d = PH_TRAILER;
				end
				PH_TRAILER: begin
					phase_d = (rx_byte == cfg.header_symbol) ? PH_TAIL : PH_HEADER;
				end
				PH_TAIL: begin
					if (rx_byte == tail_code(class_q)) begin
						phase_d        = PH_DONE;
						res.frame_done = 1'b1;
					end else begin
						phase_d = PH_HEADER;
					end
				end
				default: ;
			endcase
		end
		res.parser_state = phase_d;
		res.frame_class  = class_d;
		res.frame_length = goal_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			class_q <= '0;
			goal_q  <= '0;
			taken_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			class_q <= class_d;
			goal_q  <= goal_d;
			taken_q <= taken_d;
		end
	end

	`SFP_ASSERT_NEXT(a_done_holds, clk, arst_n, en && !op && phase_q == PH_DONE, phase_q == PH_DONE, "done state left without reset item")
	`SFP_ASSERT_NEXT(a_reset_item, clk, arst_n, en && op, phase_q == PH_MODE, "reset item did not enter mode state")
	`SFP_ASSERT_NEXT(a_count_clear, clk, arst_n, en && !op && phase_q == PH_SIZE1, taken_q == 16'd0, "payload count not cleared")

endmodule

@@ design/sensor_frame_parser.sv @@
// Top level of the sensor frame parser: input register, parser, result register.
// Depends on sfp_pkg, sfp_cfg_regs, sfp_parse and sensor_frame_parser_assert.svh.
//
// Takes one item per clock while the output is not stalled and returns exactly
// one result item for each: the item is captured in an input register, the
// parser computes its next state and result from it combinationally, and the
// result is held in an output register. Throughput is one item per cycle while
// m_tready allows it; a stalled output holds its result while the input register
// still takes one more item. Configuration writes are always ready and take
// effect on the next cycle.
`include "sensor_frame_parser_assert.svh"
module sensor_frame_parser
	import sfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // parser_state, payload_index, payload_byte,
	                               // frame_class, frame_length, zero fill
	output logic [1:0]  m_tuser,   // payload_valid, frame_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic       valid_s1, valid_s2;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       adv;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;

	sfp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	sfp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.op      (op_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.frame_length, res_s2.frame_class, res_s2.payload_byte,
		res_s2.payload_index, res_s2.parser_state};
	assign m_tuser  = {res_s2.frame_done, res_s2.payload_valid};

	`SFP_ASSERT(a_payload_state, clk, arst_n, valid_s2 && res_s2.payload_valid |-> res_s2.parser_state == PH_DATA || res_s2.parser_state == PH_TRAILER, "payload reported outside data phase")
	`SFP_ASSERT(a_done_state, clk, arst_n, valid_s2 && res_s2.frame_done |-> res_s2.parser_state == PH_DONE, "frame done without done state")
	`SFP_ASSERT(a_no_overrun, clk, arst_n, s_tready && valid_s1 |-> adv, "input register overwritten")

endmodule
